[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/isbp_pkg.sv]
// ----------------------------------------------------------------------------
// isbp_pkg
// Shared widths, register indexes, the in-flight word type and the small
// arithmetic helpers of the icon scaler.
// ----------------------------------------------------------------------------
package isbp_pkg;

  localparam int DEF_MAX_SOURCE_EDGE = 64;
  localparam int DEF_MAX_TARGET_EDGE = 2048;

  localparam int BG_W       = 24;
  localparam int TS_W       = 12;
  localparam int SE_W       = 7;
  localparam int MASK_W     = 32;
  localparam int IDX_W      = 12;
  localparam int RGBA_W     = 32;
  localparam int COORD_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int QUO_W     = SE_W;
  localparam int NUM_W     = COORD_W + SE_W;
  localparam int SHIFT_W   = 5;
  localparam int COEF_Q_W  = 25;
  localparam int RECIP_SH  = 39;
  localparam logic [MASK_W-1:0] RECIP_255 = 32'h8080_8081;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK  = 3'd6;

  localparam logic [MASK_W-1:0] RESET_RED_MASK   = 32'h00FF_0000;
  localparam logic [MASK_W-1:0] RESET_GREEN_MASK = 32'h0000_FF00;
  localparam logic [MASK_W-1:0] RESET_BLUE_MASK  = 32'h0000_00FF;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef struct packed {
    logic               act;
    logic               ok;
    logic [IDX_W-1:0]   idx;
    logic [RGBA_W-1:0]  rgba;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
  } isbp_side_t;

  // Exact floor(v / 255) for v up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // Index of the lowest set bit; zero for an empty mask.
  function automatic logic [SHIFT_W-1:0] ctz32(input logic [MASK_W-1:0] m);
    logic [SHIFT_W-1:0] n;
    n = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        n = SHIFT_W'(i);
      end
    end
    return n;
  endfunction

endpackage

[hw/rtl/isbp_div.sv]
// ----------------------------------------------------------------------------
// isbp_div
// Pipelined restoring divider for both source coordinates, one quotient bit
// per stage, carrying the in-flight word alongside.
// ----------------------------------------------------------------------------
module isbp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  isbp_pkg::isbp_side_t         in_side,
  input  logic [isbp_pkg::NUM_W-1:0]   in_num_x,
  input  logic [isbp_pkg::NUM_W-1:0]   in_num_y,
  input  logic [isbp_pkg::TS_W-1:0]    divisor,
  output logic                         out_valid,
  output isbp_pkg::isbp_side_t         out_side,
  output logic [isbp_pkg::QUO_W-1:0]   out_quo_x,
  output logic [isbp_pkg::QUO_W-1:0]   out_quo_y
);
  import isbp_pkg::*;

  logic             valid_r [QUO_W];
  isbp_side_t       side_r  [QUO_W];
  logic [NUM_W-1:0] rem_x_r [QUO_W];
  logic [NUM_W-1:0] rem_y_r [QUO_W];
  logic [QUO_W-1:0] quo_x_r [QUO_W];
  logic [QUO_W-1:0] quo_y_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;
    logic             v_in;
    isbp_side_t       side_in;
    logic [NUM_W-1:0] rx_in;
    logic [NUM_W-1:0] ry_in;
    logic [QUO_W-1:0] qx_in;
    logic [QUO_W-1:0] qy_in;
    logic [NUM_W:0]   dsh;
    logic             ge_x;
    logic             ge_y;
    logic [NUM_W-1:0] rx_nxt;
    logic [NUM_W-1:0] ry_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign rx_in   = in_num_x;
      assign ry_in   = in_num_y;
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign v_in    = valid_r[s-1];
      assign side_in = side_r[s-1];
      assign rx_in   = rem_x_r[s-1];
      assign ry_in   = rem_y_r[s-1];
      assign qx_in   = quo_x_r[s-1];
      assign qy_in   = quo_y_r[s-1];
    end

    assign dsh    = (NUM_W + 1)'(divisor) << K;
    assign ge_x   = {1'b0, rx_in} >= dsh;
    assign ge_y   = {1'b0, ry_in} >= dsh;
    assign rx_nxt = ge_x ? (rx_in - dsh[NUM_W-1:0]) : rx_in;
    assign ry_nxt = ge_y ? (ry_in - dsh[NUM_W-1:0]) : ry_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s]  <= side_in;
        rem_x_r[s] <= rx_nxt;
        rem_y_r[s] <= ry_nxt;
        quo_x_r[s] <= {qx_in[QUO_W-2:0], ge_x};
        quo_y_r[s] <= {qy_in[QUO_W-2:0], ge_y};
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_quo_x = quo_x_r[QUO_W-1];
  assign out_quo_y = quo_y_r[QUO_W-1];

endmodule

[hw/rtl/isbp_store.sv]
// ----------------------------------------------------------------------------
// isbp_store
// Source icon memory. Loads write and renders read in the same stage, so the
// order of accesses is the order of the accepted words.
// ----------------------------------------------------------------------------
module isbp_store #(
  parameter int MAX_SOURCE_EDGE = isbp_pkg::DEF_MAX_SOURCE_EDGE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  isbp_pkg::isbp_side_t          in_side,
  input  logic [isbp_pkg::QUO_W-1:0]    in_sx,
  input  logic [isbp_pkg::QUO_W-1:0]    in_sy,
  input  logic [isbp_pkg::SE_W-1:0]     source_width,
  output logic                          out_valid,
  output isbp_pkg::isbp_side_t          out_side,
  output logic [isbp_pkg::RGBA_W-1:0]   out_pixel
);
  import isbp_pkg::*;

  localparam int DEPTH = MAX_SOURCE_EDGE * MAX_SOURCE_EDGE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] DEPTH_V = 32'(DEPTH);
  localparam int RA_W  = 2 * SE_W;

  logic [RGBA_W-1:0] mem [DEPTH];

  logic            a_valid_r;
  logic            a_wr_r;
  isbp_side_t      a_side_r;
  logic [AW-1:0]   a_addr_r;
  logic [AW-1:0]   addr_nxt;
  logic            wr_nxt;
  logic [RA_W-1:0] raddr;

  logic              b_valid_r;
  isbp_side_t        b_side_r;
  logic [RGBA_W-1:0] rd_r;

  assign raddr = RA_W'(in_sy) * RA_W'(source_width) + RA_W'(in_sx);

  always_comb begin
    if (in_side.act == ACT_LOAD) begin
      addr_nxt = AW'(in_side.idx);
      wr_nxt   = in_valid && (32'(in_side.idx) < DEPTH_V);
    end else begin
      addr_nxt = AW'(raddr);
      wr_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r && (a_side_r.act == ACT_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= in_side;
      a_addr_r <= addr_nxt;
      a_wr_r   <= wr_nxt;
      b_side_r <= a_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && a_valid_r && a_wr_r) begin
      mem[a_addr_r] <= a_side_r.rgba;
    end
    if (en && a_valid_r && (a_side_r.act == ACT_RENDER)) begin
      rd_r <= mem[a_addr_r];
    end
  end

  assign out_valid = b_valid_r;
  assign out_side  = b_side_r;
  assign out_pixel = rd_r;

endmodule

[hw/rtl/isbp_blend.sv]
// ----------------------------------------------------------------------------
// isbp_blend
// Blends the three colors of the source pixel over the background by its
// alpha, truncating the division by 255.
// ----------------------------------------------------------------------------
module isbp_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  isbp_pkg::isbp_side_t         in_side,
  input  logic [isbp_pkg::RGBA_W-1:0]  in_pixel,
  input  logic [isbp_pkg::BG_W-1:0]    background,
  output logic                         out_valid,
  output isbp_pkg::isbp_side_t         out_side,
  output logic [isbp_pkg::BG_W-1:0]    out_rgb
);
  import isbp_pkg::*;

  logic            valid_r;
  isbp_side_t      side_r;
  logic [BG_W-1:0] rgb_r;
  logic [BG_W-1:0] rgb_nxt;
  logic [7:0]      alpha;

  assign alpha = in_pixel[7:0];

  // Channel 0 is blue, 1 green, 2 red in both the pixel and the background.
  always_comb begin
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [15:0] v;
    rgb_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      fg = in_pixel[8*i+15 -: 8];
      bg = background[8*i+7 -: 8];
      v  = 16'(fg) * 16'(alpha) + 16'(bg) * 16'(8'd255 - alpha);
      rgb_nxt[8*i+7 -: 8] = div255(v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      rgb_r  <= rgb_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_rgb   = rgb_r;

endmodule

[hw/rtl/isbp_pack.sv]
// ----------------------------------------------------------------------------
// isbp_pack
// Packs the blended colors into the output word. Each mask is reduced once to
// its shift and to the quotient and remainder of its unit by 255, so a pixel
// needs only narrow multiplies and a small division by 255.
// ----------------------------------------------------------------------------
module isbp_pack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  isbp_pkg::isbp_side_t         in_side,
  input  logic [isbp_pkg::BG_W-1:0]    in_rgb,
  input  logic [isbp_pkg::MASK_W-1:0]  red_field,
  input  logic [isbp_pkg::MASK_W-1:0]  green_field,
  input  logic [isbp_pkg::MASK_W-1:0]  blue_field,
  output logic                         out_valid,
  output logic [isbp_pkg::MASK_W-1:0]  out_pixel_word,
  output logic                         out_drawn,
  output logic [isbp_pkg::COORD_W-1:0] out_x,
  output logic [isbp_pkg::COORD_W-1:0] out_y
);
  import isbp_pkg::*;

  logic [MASK_W-1:0]   cmask    [3];
  logic [SHIFT_W-1:0]  shift_r  [3];
  logic [MASK_W-1:0]   mask_d_r [3];
  logic [MASK_W-1:0]   unit_r   [3];
  logic [MASK_W-1:0]   unit_d_r [3];
  logic [63:0]         prod_r   [3];
  logic [COEF_Q_W-1:0] quo_r    [3];
  logic [7:0]          rem_r    [3];
  logic [MASK_W-1:0]   scaled_r [3];

  logic              p_valid_r;
  isbp_side_t        p_side_r;
  logic              o_valid_r;
  logic [MASK_W-1:0] o_word_r;
  logic              o_drawn_r;
  logic [COORD_W-1:0] o_x_r;
  logic [COORD_W-1:0] o_y_r;
  logic [MASK_W-1:0] word_nxt;

  assign cmask[0] = blue_field;
  assign cmask[1] = green_field;
  assign cmask[2] = red_field;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [7:0]          level;
    logic [COEF_Q_W-1:0] q_nxt;
    logic [MASK_W-1:0]   q255;
    logic [MASK_W:0]     cq;
    logic [7:0]          low;

    assign level = in_rgb[8*c+7 -: 8];
    assign q_nxt = prod_r[c][RECIP_SH +: COEF_Q_W];
    assign q255  = (MASK_W'(q_nxt) << 8) - MASK_W'(q_nxt);
    assign cq    = (MASK_W + 1)'(level) * (MASK_W + 1)'(quo_r[c]);
    assign low   = div255(16'(level) * 16'(rem_r[c]) + 16'd127);

    // Mask coefficients in order: shift, unit, product, quotient, remainder.
    always_ff @(posedge clk) begin
      shift_r[c]  <= ctz32(cmask[c]);
      mask_d_r[c] <= cmask[c];
      unit_r[c]   <= mask_d_r[c] >> shift_r[c];
      prod_r[c]   <= 64'(unit_r[c]) * 64'(RECIP_255);
      unit_d_r[c] <= unit_r[c];
      quo_r[c]    <= q_nxt;
      rem_r[c]    <= 8'(unit_d_r[c] - q255);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        scaled_r[c] <= cq[MASK_W-1:0] + MASK_W'(low);
      end
    end
  end

  always_comb begin
    word_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      word_nxt = word_nxt | ((scaled_r[i] << shift_r[i]) & cmask[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_valid;
      o_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side_r  <= in_side;
      o_word_r  <= p_side_r.ok ? word_nxt : '0;
      o_drawn_r <= p_side_r.ok;
      o_x_r     <= p_side_r.dx;
      o_y_r     <= p_side_r.dy;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_pixel_word = o_word_r;
  assign out_drawn      = o_drawn_r;
  assign out_x          = o_x_r;
  assign out_y          = o_y_r;

endmodule

[hw/rtl/icon_scale_blend_pack.sv]
// ----------------------------------------------------------------------------
// icon_scale_blend_pack
// Nearest-neighbor icon scaler with alpha blend over a background and packing
// into the color masks of the output word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word per cycle. A load word (action 0) writes
//   one RGBA pixel into the icon memory and yields no result. A render word
//   (action 1) yields one result word with the packed pixel, the drawn flag
//   and the echoed coordinates; an invalid size or a coordinate outside the
//   target gives drawn 0 and a zero pixel.
//   Throughput is one word per cycle while no stall holds the pipeline. A render
//   result passes through one input stage, seven divider stages (one quotient bit
//   each for the source column and row), address and memory stages, blend,
//   channel scaling and the output register.
//   Loads and renders reach the memory port in the same stage and in order,
//   so a render always sees every load accepted before it.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall is raised; nothing is dropped.
//   Reset clears the pipeline and the registers to their defaults. The icon
//   memory is not cleared; render only pixels that were loaded.
//   Write registers only while no word is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icon_scale_blend_pack #(
  parameter int MAX_SOURCE_EDGE = isbp_pkg::DEF_MAX_SOURCE_EDGE,
  parameter int MAX_TARGET_EDGE = isbp_pkg::DEF_MAX_TARGET_EDGE
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_we,
  input  logic [isbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isbp_pkg::CFG_DATA_W-1:0] cfg_wdata,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [isbp_pkg::IDX_W-1:0]      in_source_index,
  input  logic [isbp_pkg::RGBA_W-1:0]     in_source_rgba,
  input  logic [isbp_pkg::COORD_W-1:0]    in_dest_x,
  input  logic [isbp_pkg::COORD_W-1:0]    in_dest_y,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [isbp_pkg::MASK_W-1:0]     out_pixel_word,
  output logic                            out_drawn,
  output logic [isbp_pkg::COORD_W-1:0]    out_x,
  output logic [isbp_pkg::COORD_W-1:0]    out_y
);
  import isbp_pkg::*;

  logic [BG_W-1:0]   background_r;
  logic [TS_W-1:0]   target_size_r;
  logic [SE_W-1:0]   source_width_r;
  logic [SE_W-1:0]   source_height_r;
  logic [MASK_W-1:0] red_field_r;
  logic [MASK_W-1:0] green_field_r;
  logic [MASK_W-1:0] blue_field_r;

  logic             adv;
  logic             accept;
  logic             ok_nxt;
  isbp_side_t       side_nxt;
  logic             s1_valid_r;
  isbp_side_t       s1_side_r;
  logic [NUM_W-1:0] s1_num_x_r;
  logic [NUM_W-1:0] s1_num_y_r;

  logic             div_valid;
  isbp_side_t       div_side;
  logic [QUO_W-1:0] div_sx;
  logic [QUO_W-1:0] div_sy;

  logic              st_valid;
  isbp_side_t        st_side;
  logic [RGBA_W-1:0] st_pixel;

  logic            bl_valid;
  isbp_side_t      bl_side;
  logic [BG_W-1:0] bl_rgb;

  logic                         res_undrawn;
  logic                         res_drawn;
  logic                         res_inside;
  logic                         pixel_zero;
  logic                         icon_sized;
  logic [$bits(isbp_side_t):0]  s1_word;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      background_r    <= '0;
      target_size_r   <= '0;
      source_width_r  <= '0;
      source_height_r <= '0;
      red_field_r     <= RESET_RED_MASK;
      green_field_r   <= RESET_GREEN_MASK;
      blue_field_r    <= RESET_BLUE_MASK;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKGROUND: background_r    <= cfg_wdata[BG_W-1:0];
        CFG_TARGET:     target_size_r   <= cfg_wdata[TS_W-1:0];
        CFG_SRC_WIDTH:  source_width_r  <= cfg_wdata[SE_W-1:0];
        CFG_SRC_HEIGHT: source_height_r <= cfg_wdata[SE_W-1:0];
        CFG_RED_MASK:   red_field_r     <= cfg_wdata[MASK_W-1:0];
        CFG_GREEN_MASK: green_field_r   <= cfg_wdata[MASK_W-1:0];
        CFG_BLUE_MASK:  blue_field_r    <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign ok_nxt = (source_width_r != '0) &&
                  (32'(source_width_r) <= 32'(MAX_SOURCE_EDGE)) &&
                  (source_height_r != '0) &&
                  (32'(source_height_r) <= 32'(MAX_SOURCE_EDGE)) &&
                  (target_size_r != '0) &&
                  (32'(target_size_r) <= 32'(MAX_TARGET_EDGE)) &&
                  (TS_W'(in_dest_x) < target_size_r) &&
                  (TS_W'(in_dest_y) < target_size_r);

  always_comb begin
    side_nxt.act  = in_action;
    side_nxt.ok   = ok_nxt;
    side_nxt.idx  = in_source_index;
    side_nxt.rgba = in_source_rgba;
    side_nxt.dx   = in_dest_x;
    side_nxt.dy   = in_dest_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r  <= side_nxt;
      s1_num_x_r <= NUM_W'(in_dest_x) * NUM_W'(source_width_r);
      s1_num_y_r <= NUM_W'(in_dest_y) * NUM_W'(source_height_r);
    end
  end

  isbp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s1_valid_r),
    .in_side   (s1_side_r),
    .in_num_x  (s1_num_x_r),
    .in_num_y  (s1_num_y_r),
    .divisor   (target_size_r),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_quo_x (div_sx),
    .out_quo_y (div_sy)
  );

  isbp_store #(
    .MAX_SOURCE_EDGE (MAX_SOURCE_EDGE)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .in_valid     (div_valid),
    .in_side      (div_side),
    .in_sx        (div_sx),
    .in_sy        (div_sy),
    .source_width (source_width_r),
    .out_valid    (st_valid),
    .out_side     (st_side),
    .out_pixel    (st_pixel)
  );

  isbp_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_valid   (st_valid),
    .in_side    (st_side),
    .in_pixel   (st_pixel),
    .background (background_r),
    .out_valid  (bl_valid),
    .out_side   (bl_side),
    .out_rgb    (bl_rgb)
  );

  isbp_pack u_pack (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (adv),
    .in_valid       (bl_valid),
    .in_side        (bl_side),
    .in_rgb         (bl_rgb),
    .red_field      (red_field_r),
    .green_field    (green_field_r),
    .blue_field     (blue_field_r),
    .out_valid      (out_valid),
    .out_pixel_word (out_pixel_word),
    .out_drawn      (out_drawn),
    .out_x          (out_x),
    .out_y          (out_y)
  );

  assign res_undrawn = out_valid && !out_drawn;
  assign res_drawn   = out_valid && out_drawn;
  assign res_inside  = (TS_W'(out_x) < target_size_r) && (TS_W'(out_y) < target_size_r);
  assign pixel_zero  = (out_pixel_word == '0);
  assign icon_sized  = (source_width_r != '0) && (source_height_r != '0);
  assign s1_word     = {s1_valid_r, s1_side_r};

  `ASSERT_NOW(a_undrawn_zero, clk, rst_n, res_undrawn, pixel_zero, "nonzero undrawn pixel")
  `ASSERT_NOW(a_drawn_inside, clk, rst_n, res_drawn, res_inside, "drawn outside target")
  `ASSERT_NOW(a_drawn_icon, clk, rst_n, res_drawn, icon_sized, "drawn with empty icon")
  `ASSERT_NEXT(a_stall_holds_entry, clk, rst_n, in_stall, $stable(s1_word), "input moved in stall")

endmodule
